// File: design/hpe_pkg.sv
// Shared types, constants and helper functions for the header property extractor.
package hpe_pkg;

   localparam int NAME_MAX    = 8;
   localparam int WIN_W       = NAME_MAX * 8;
   localparam int FILL_W      = $clog2(NAME_MAX + 1);
   localparam int IDX_W       = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam int LEN_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROPERTY_NAME = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LENGTH   = CSR_INDEX_W'(1);

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef enum logic [2:0] {
      PH_SEARCH     = 3'd0,
      PH_PRE_COLON  = 3'd1,
      PH_POST_COLON = 3'd2,
      PH_VALUE      = 3'd3,
      PH_DONE       = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_FOUND     = 2'd1,
      KIND_NOT_FOUND = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic       header_end;
   } item_type;

   typedef struct packed {
      kind_type   result_kind;
      logic [7:0] value_byte;
      logic       final_mark;
   } result_type;

   typedef struct packed {
      logic [NAME_MAX-1:0][7:0] name;
      logic [FILL_W-1:0]        length;
   } cfg_type;

   // ASCII upper case letters fold to lower case; everything else passes.
   function automatic logic [7:0] fold_case(logic [7:0] b);
      if (b >= 8'h41 && b <= 8'h5A) begin
         return b + 8'h20;
      end
      return b;
   endfunction

   // Out of range lengths are pulled into 1..NAME_MAX.
   function automatic logic [FILL_W-1:0] eff_length(logic [LEN_W-1:0] n);
      if (n == '0) begin
         return FILL_W'(1);
      end
      if (n > LEN_W'(NAME_MAX)) begin
         return FILL_W'(NAME_MAX);
      end
      return FILL_W'(n);
   endfunction

endpackage

// File: design/hpe_if.sv
// Handshake channel interfaces for requests, results and register writes.
interface hpe_req_if;
   import hpe_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       header_end;
   modport source (output valid, output header_byte, output header_end, input ready);
   modport sink   (input valid, input header_byte, input header_end, output ready);
endinterface

interface hpe_rsp_if;
   import hpe_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] value_byte;
   logic       final_mark;
   modport source (output valid, output result_kind, output value_byte, output final_mark,
                   input ready);
   modport sink   (input valid, input result_kind, input value_byte, input final_mark,
                   output ready);
endinterface

interface hpe_csr_if;
   import hpe_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: design/hpe_match.sv
// Case-insensitive compare of the sliding byte window against the property name.
module hpe_match (
   input  logic [hpe_pkg::WIN_W-1:0]  window,
   input  logic [hpe_pkg::FILL_W-1:0] fill,
   input  hpe_pkg::cfg_type           cfg,
   output logic                       match
);
   import hpe_pkg::*;

   logic [NAME_MAX-1:0][7:0] win_bytes;

   assign win_bytes = window;

   // Name character i lines up with window byte length-1-i; newest byte is byte 0.
   always_comb begin
      logic              all_eq;
      logic [FILL_W-1:0] pos;
      all_eq = 1'b1;
      pos    = '0;
      for (int i = 0; i < NAME_MAX; i++) begin
         pos = cfg.length - FILL_W'(1) - FILL_W'(i);
         if (FILL_W'(i) < cfg.length) begin
            if (fold_case(cfg.name[i]) != fold_case(win_bytes[pos[IDX_W-1:0]])) begin
               all_eq = 1'b0;
            end
         end
      end
      match = all_eq && (fill >= cfg.length);
   end

endmodule

// File: design/hpe_core.sv
// Search state, phase sequencing and result generation for one header byte per beat.
module hpe_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  logic                advance,
   input  hpe_pkg::item_type   item,
   input  hpe_pkg::cfg_type    cfg,
   output logic                res_valid,
   output hpe_pkg::result_type res
);
   import hpe_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [WIN_W-1:0]  window_ff, window_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              seen_ff, seen_in;

   logic [WIN_W-1:0]  shifted;
   logic [FILL_W-1:0] fill_up;
   logic              match;
   logic              is_term;
   logic              last;
   logic [7:0]        hb;

   assign hb      = item.header_byte;
   assign last    = item.header_end;
   assign is_term = (hb == CHAR_CR) || (hb == CHAR_LF);
   assign shifted = (window_ff << 8) | WIN_W'(hb);
   assign fill_up = (fill_ff < FILL_W'(NAME_MAX)) ? fill_ff + FILL_W'(1) : fill_ff;

   hpe_match u_match (
      .window (shifted),
      .fill   (fill_up),
      .cfg    (cfg),
      .match  (match)
   );

   always_comb begin
      phase_in  = phase_ff;
      window_in = window_ff;
      fill_in   = fill_ff;
      seen_in   = seen_ff;
      if (advance) begin
         unique case (phase_ff)
            PH_SEARCH: begin
               window_in = shifted;
               fill_in   = fill_up;
               if (!last && match) begin
                  phase_in = PH_PRE_COLON;
               end
            end
            PH_PRE_COLON: begin
               if (!last && hb == CHAR_COLON) begin
                  phase_in = PH_POST_COLON;
               end else if (!last && hb != CHAR_SPACE) begin
                  phase_in = PH_DONE;
               end
            end
            PH_POST_COLON: begin
               if (!last && is_term) begin
                  phase_in = PH_DONE;
               end else if (!last && hb != CHAR_SPACE) begin
                  phase_in = PH_VALUE;
                  seen_in  = 1'b1;
               end
            end
            PH_VALUE: begin
               if (!last && is_term) begin
                  phase_in = PH_DONE;
               end else if (!last) begin
                  seen_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
         // The header's last byte always rearms the search.
         if (last) begin
            phase_in  = PH_SEARCH;
            window_in = '0;
            fill_in   = '0;
            seen_in   = 1'b0;
         end
      end
   end

   always_comb begin
      logic emit;
      emit            = 1'b0;
      res.result_kind = KIND_NOT_FOUND;
      res.value_byte  = 8'h00;
      res.final_mark  = 1'b1;
      unique case (phase_ff)
         PH_SEARCH: begin
            emit = last;
         end
         PH_PRE_COLON: begin
            emit = last || (hb != CHAR_SPACE && hb != CHAR_COLON);
         end
         PH_POST_COLON: begin
            if (last || is_term) begin
               emit = 1'b1;
            end else if (hb != CHAR_SPACE) begin
               emit            = 1'b1;
               res.result_kind = KIND_BYTE;
               res.value_byte  = hb;
               res.final_mark  = 1'b0;
            end
         end
         PH_VALUE: begin
            emit = 1'b1;
            if (is_term && !last) begin
               res.result_kind = seen_ff ? KIND_FOUND : KIND_NOT_FOUND;
            end else if (!last) begin
               res.result_kind = KIND_BYTE;
               res.value_byte  = hb;
               res.final_mark  = 1'b0;
            end
         end
         default: begin
         end
      endcase
      res_valid = item_valid && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEARCH;
         window_ff <= '0;
         fill_ff   <= '0;
         seen_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         fill_ff   <= fill_in;
         seen_ff   <= seen_in;
      end
   end

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      (advance && item.header_end) |=> (phase_ff == PH_SEARCH && fill_ff == '0 && !seen_ff))
      else $error("header end did not rearm the search");

   a_value_seen: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_VALUE) |-> seen_ff)
      else $error("value phase entered without a value byte");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(NAME_MAX))
      else $error("window fill count beyond the window size");

endmodule

// File: design/header_property_extractor_top.sv
// Top level of the header property extractor: beat registers, config registers, core.
//
// Header text enters one byte per beat on req_if, with header_end set on a header's last
// byte. The block finds the first case-insensitive match of the property name, checks for
// a colon, and returns the value bytes (kind 0) followed by one closing beat marked
// final_mark: kind 1 when a non-empty value ended in CR or LF before the header ended,
// kind 2 otherwise. Bytes after the closing beat are dropped until the header's last byte.
// One byte is taken every cycle while rsp_if is not stalled; each byte is held in the input
// register and its result is then held in the result register. The window compare and
// phase update sit between those two registers. Register writes on csr_if are always ready and
// must be made while no header bytes are in flight.
module header_property_extractor_top (
   input  logic  clock,
   input  logic  reset,
   hpe_req_if.sink   req_if,
   hpe_rsp_if.source rsp_if,
   hpe_csr_if.sink   csr_if
);
   import hpe_pkg::*;

   logic                     in_valid_ff, in_valid_in;
   item_type                 in_item_ff, in_item_in;
   logic                     out_valid_ff, out_valid_in;
   result_type               out_res_ff, out_res_in;
   logic [NAME_MAX-1:0][7:0] name_ff, name_in;
   logic [LEN_W-1:0]         length_ff, length_in;

   cfg_type    cfg;
   logic       advance;
   logic       res_valid;
   result_type res;
   logic       req_take;

   // An item leaves the input register whenever the result register is free or draining.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_take      = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   assign cfg.name   = name_ff;
   assign cfg.length = eff_length(length_ff);

   hpe_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .advance    (advance),
      .item       (in_item_ff),
      .cfg        (cfg),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in            = 1'b1;
         in_item_in.header_byte = req_if.header_byte;
         in_item_in.header_end  = req_if.header_end;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (advance) begin
         out_valid_in = res_valid;
         out_res_in   = res;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      name_in   = name_ff;
      length_in = length_ff;
      if (csr_if.valid && csr_if.ready) begin
         if (csr_if.reg_index == CSR_PROPERTY_NAME) begin
            name_in = csr_if.wdata[WIN_W-1:0];
         end else if (csr_if.reg_index == CSR_NAME_LENGTH) begin
            length_in = csr_if.wdata[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         name_ff      <= '0;
         length_ff    <= LEN_W'(1);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         name_ff      <= name_in;
         length_ff    <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.result_kind = out_res_ff.result_kind;
   assign rsp_if.value_byte  = out_res_ff.value_byte;
   assign rsp_if.final_mark  = out_res_ff.final_mark;

   a_kind_final: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_res_ff.final_mark == (out_res_ff.result_kind != KIND_BYTE)))
      else $error("final mark disagrees with result kind");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.result_kind != KIND_BYTE) |-> out_res_ff.value_byte == 8'h00)
      else $error("closing beat carries a nonzero value byte");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (in_valid_ff && out_valid_ff && !rsp_if.ready))
      else $error("request side stalled with room in the pipeline");

endmodule

// File: test/header_property_extractor_top_test.sv
// Self-checking testbench for the header property extractor top level.
`timescale 1ns / 1ps

module header_property_extractor_top_test;
   import hpe_pkg::*;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int SETTLE_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int REPORT_CAP      = 100;

   // Indexes past the two registers; writes to them must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = CSR_INDEX_W'(3);

   class header_scoreboard;
      logic [63:0] name_reg;
      logic [3:0]  length_reg;
      logic [63:0] window;
      logic [3:0]  fill;
      phase_type   phase_now;
      bit          value_emitted;
      result_type  expected_q[$];
      int          mismatches;
      int          bytes_in;
      int          beats_out;
      int          found_count;

      function new();
         name_reg    = '0;
         length_reg  = 4'd1;
         mismatches  = 0;
         bytes_in    = 0;
         beats_out   = 0;
         found_count = 0;
         rearm();
      endfunction

      function void rearm();
         window        = '0;
         fill          = '0;
         phase_now     = PH_SEARCH;
         value_emitted = 1'b0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic [7:0] to_lower(logic [7:0] b);
         if (b >= 8'h41 && b <= 8'h5A) begin
            return b | 8'h20;
         end
         return b;
      endfunction

      function int active_length();
         if (length_reg == 4'd0) begin
            return 1;
         end
         if (length_reg > 4'(NAME_MAX)) begin
            return NAME_MAX;
         end
         return int'(length_reg);
      endfunction

      // The first name character lines up with the oldest of the newest n bytes in the window.
      function bit window_hit();
         int n;
         n = active_length();
         if (int'(fill) < n) begin
            return 1'b0;
         end
         for (int i = 0; i < n; i++) begin
            if (to_lower(name_reg[8*i +: 8]) != to_lower(window[8*(n-1-i) +: 8])) begin
               return 1'b0;
            end
         end
         return 1'b1;
      endfunction

      function void push_result(kind_type k, logic [7:0] b, logic f);
         result_type r;
         r.result_kind = k;
         r.value_byte  = b;
         r.final_mark  = f;
         expected_q.push_back(r);
      endfunction

      function void close_with(kind_type k, bit last);
         push_result(k, 8'h00, 1'b1);
         if (last) begin
            rearm();
         end else begin
            phase_now = PH_DONE;
         end
      endfunction

      function void store_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_PROPERTY_NAME) begin
            name_reg = data;
         end else if (idx == CSR_NAME_LENGTH) begin
            length_reg = data[3:0];
         end
      endfunction

      function void note_input(logic [7:0] b, logic last);
         bit is_term;
         is_term = (b == CHAR_CR) || (b == CHAR_LF);
         bytes_in++;
         case (phase_now)
            PH_SEARCH: begin
               window = {window[55:0], b};
               if (fill < 4'(NAME_MAX)) begin
                  fill++;
               end
               if (window_hit()) begin
                  if (last) begin
                     close_with(KIND_NOT_FOUND, 1'b1);
                  end else begin
                     phase_now = PH_PRE_COLON;
                  end
               end else if (last) begin
                  close_with(KIND_NOT_FOUND, 1'b1);
               end
            end
            PH_PRE_COLON: begin
               if (last || (b != CHAR_SPACE && b != CHAR_COLON)) begin
                  close_with(KIND_NOT_FOUND, last);
               end else if (b == CHAR_COLON) begin
                  phase_now = PH_POST_COLON;
               end
            end
            PH_POST_COLON: begin
               if (last || is_term) begin
                  close_with(KIND_NOT_FOUND, last);
               end else if (b != CHAR_SPACE) begin
                  phase_now     = PH_VALUE;
                  value_emitted = 1'b1;
                  push_result(KIND_BYTE, b, 1'b0);
               end
            end
            PH_VALUE: begin
               if (is_term && !last) begin
                  close_with(value_emitted ? KIND_FOUND : KIND_NOT_FOUND, 1'b0);
               end else if (last) begin
                  close_with(KIND_NOT_FOUND, 1'b1);
               end else begin
                  value_emitted = 1'b1;
                  push_result(KIND_BYTE, b, 1'b0);
               end
            end
            default: begin
               if (last) begin
                  rearm();
               end
            end
         endcase
      endfunction

      task report(string msg);
         if (mismatches < REPORT_CAP) begin
            $display("MISMATCH at result beat %0d: %s", beats_out, msg);
         end
         mismatches++;
      endtask

      task check_result(logic [1:0] kind, logic [7:0] vb, logic fm);
         result_type want;
         beats_out++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected beat kind %0d byte %02h final %0b", kind, vb, fm));
            return;
         end
         want = expected_q.pop_front();
         if (want.result_kind == KIND_FOUND) begin
            found_count++;
         end
         if (kind !== want.result_kind || vb !== want.value_byte || fm !== want.final_mark) begin
            report($sformatf("got kind %0d byte %02h final %0b, expected kind %0d byte %02h final %0b",
                             kind, vb, fm, want.result_kind, want.value_byte, want.final_mark));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   hpe_req_if req_if();
   hpe_rsp_if rsp_if();
   hpe_csr_if csr_if();

   header_property_extractor_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   header_scoreboard sb;
   bit quiet      = 1'b0;
   bit send_calm  = 1'b0;
   bit rsp_calm   = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side back-pressure: short random stalls, with calm stretches.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready = 1'b0;
         stall_left--;
      end else if (!quiet && !rsp_calm && $urandom_range(0, 5) == 0) begin
         rsp_if.ready = 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_if.ready = 1'b1;
      end
      if ($urandom_range(0, 99) == 0) begin
         rsp_calm = !rsp_calm;
      end
   end

   // Results are checked before the same edge's input beat is noted; a result
   // never belongs to a byte accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_result(rsp_if.result_kind, rsp_if.value_byte, rsp_if.final_mark);
         end
         if (req_if.valid && req_if.ready) begin
            sb.note_input(req_if.header_byte, req_if.header_end);
         end
         if (csr_if.valid && csr_if.ready) begin
            sb.store_register(csr_if.reg_index, csr_if.wdata);
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_item(input logic [7:0] b, input logic last);
      int gap;
      if (!quiet && !send_calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.header_byte = b;
      req_if.header_end  = last;
      req_if.valid       = 1'b1;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic send_chars(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) begin
         send_item(s[i], close && (i == s.len() - 1));
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_if.reg_index = idx;
      csr_if.wdata     = data;
      csr_if.valid     = 1'b1;
      @(posedge clock);
      while (!csr_if.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_if.valid = 1'b0;
      @(negedge clock);
   endtask

   // Wait until every expected beat is back, then let any silent byte drain.
   task automatic settle();
      req_if.valid = 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly well-formed headers built around the current name, plus raw noise.
   task automatic run_phase(input int n_items);
      logic [7:0] hdr[$];
      logic [7:0] c;
      int count;
      int len;
      count = 0;
      while (count < n_items) begin
         hdr.delete();
         send_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 12)) hdr.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(0, 5)) hdr.push_back(8'($urandom_range(0, 255)));
            len = sb.active_length();
            for (int k = 0; k < len; k++) begin
               c = sb.name_reg[8*k +: 8];
               // Flip the case of letters at random; the match must ignore it.
               if (((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A) && $urandom_range(0, 1)) begin
                  c = c ^ 8'h20;
               end
               hdr.push_back(c);
            end
            repeat ($urandom_range(0, 2)) hdr.push_back(CHAR_SPACE);
            if ($urandom_range(0, 9) != 0) begin
               hdr.push_back(CHAR_COLON);
            end else begin
               hdr.push_back(8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(0, 2)) hdr.push_back(CHAR_SPACE);
            repeat ($urandom_range(0, 5)) begin
               do begin
                  c = 8'($urandom_range(0, 255));
               end while (c == CHAR_CR || c == CHAR_LF);
               hdr.push_back(c);
            end
            if ($urandom_range(0, 5) != 0) begin
               hdr.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            end
            repeat ($urandom_range(0, 3)) hdr.push_back(8'($urandom_range(0, 255)));
         end
         for (int k = 0; k < hdr.size(); k++) begin
            send_item(hdr[k], k == hdr.size() - 1);
         end
         count += hdr.size();
      end
   endtask

   initial begin
      logic [63:0] nm;
      logic [3:0]  ln;
      sb = new();
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.header_byte = 8'h00;
      req_if.header_end  = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.reg_index   = CSR_PROPERTY_NAME;
      csr_if.wdata       = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed headers on a one-letter name, stored in upper case.
      write_csr(CSR_PROPERTY_NAME, 64'h41);
      write_csr(CSR_NAME_LENGTH, 64'd1);
      send_chars("a:x\n", 1'b0);
      send_item(8'hFF, 1'b1);
      send_chars("A", 1'b1);
      send_chars("a :", 1'b1);
      send_chars("a: ", 1'b1);
      send_chars("abc", 1'b1);
      send_chars("a:\r", 1'b0);
      send_item(8'h00, 1'b1);
      send_chars("a:xy", 1'b1);
      send_chars("zz", 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         if (p == 0) begin
            nm = '0;
            ln = 4'd0;
         end else if (p == PHASES - 1) begin
            nm = '1;
            ln = 4'hF;
         end else begin
            for (int k = 0; k < 8; k++) begin
               if ($urandom_range(0, 4) == 0) begin
                  nm[8*k +: 8] = 8'($urandom_range(0, 255));
               end else begin
                  nm[8*k +: 8] = (8'h61 + 8'($urandom_range(0, 25))) ^
                                 ($urandom_range(0, 1) ? 8'h20 : 8'h00);
               end
            end
            if (p == 1) begin
               ln = 4'd8;
            end else if ($urandom_range(0, 5) == 0) begin
               ln = 4'($urandom_range(9, 15));
            end else begin
               ln = 4'($urandom_range(1, 8));
            end
         end
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_PROPERTY_NAME, nm);
            write_csr(CSR_NAME_LENGTH, {$urandom, 28'($urandom), ln});
         end else begin
            write_csr(CSR_NAME_LENGTH, {$urandom, 28'($urandom), ln});
            write_csr(CSR_PROPERTY_NAME, nm);
         end
         if (p == 0 || $urandom_range(0, 2) == 0) begin
            write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, {$urandom, $urandom});
         end
         quiet = (p == PHASES - 1);
         run_phase(ITEMS_PER_PHASE);
      end
      settle();

      $display("Sent %0d header bytes over %0d name settings plus the directed headers.",
               sb.bytes_in, PHASES);
      $display("Checked %0d result beats, %0d of them closing a found value; %0d mismatches.",
               sb.beats_out, sb.found_count, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
